// File: hw/rtl/two_priority_batch_uploader_core_macros.svh
// Assertion macros used by the checker file of the batch uploader.
`ifndef TWO_PRIORITY_BATCH_UPLOADER_CORE_MACROS_SVH
`define TWO_PRIORITY_BATCH_UPLOADER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPBU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same cycle");

// Consequent must hold in the cycle after the antecedent.
`define TPBU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next cycle");

`endif

// File: hw/rtl/tpbu_pkg.sv
// Constants, field widths and codes of the two-priority batch uploader.
package tpbu_pkg;

    localparam int PACKET_MAX   = 32;
    localparam int PRIO_DEPTH   = 64;
    localparam int NORMAL_LIMIT = 256;
    localparam int WORD_BITS    = 32;

    // Request and result field widths.
    localparam int KIND_W     = 2;
    localparam int EVENT_W    = 32;
    localparam int SIZE_W     = 6;
    localparam int PRIO_OUT_W = 7;
    localparam int NORM_OUT_W = 9;

    localparam int IN_TUSER_W  = KIND_W + 1;
    localparam int OUT_FIELD_W = EVENT_W + SIZE_W + PRIO_OUT_W + NORM_OUT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Stored word width: the event word masked to WORD_BITS.
    localparam int STORE_W = (WORD_BITS < EVENT_W) ? WORD_BITS : EVENT_W;

    localparam int PRIO_AW = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
    localparam int PRIO_CW = $clog2(PRIO_DEPTH + 1);
    localparam int NORM_AW = (NORMAL_LIMIT > 1) ? $clog2(NORMAL_LIMIT) : 1;
    localparam int NORM_CW = $clog2(NORMAL_LIMIT + 1);
    localparam int PKT_AW  = (PACKET_MAX > 1) ? $clog2(PACKET_MAX) : 1;
    localparam int PKT_CW  = $clog2(PACKET_MAX + 1);

    typedef logic [KIND_W-1:0] kind_t;

    // Request kinds.
    localparam kind_t KIND_APPEND = 2'd0;
    localparam kind_t KIND_TICK   = 2'd1;
    localparam kind_t KIND_DONE   = 2'd2;
    localparam kind_t KIND_FAILED = 2'd3;

    // Result kinds.
    localparam kind_t RK_ACCEPT = 2'd0;
    localparam kind_t RK_DROP   = 2'd1;
    localparam kind_t RK_ENTRY  = 2'd2;

endpackage

// File: hw/rtl/tpbu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tpbu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/two_priority_batch_uploader_core.sv
// Top level of the two-priority batch uploader: queues, packet fill and emission.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready  | tdata: event_word; tuser: kind, high_priority
//  m_axis   | out       | m_axis_tvalid/tready  | tdata: entry word + status; tuser: result_kind;
//           |           |                       | tlast: last_in_packet
//
// One request is taken at a time. A normal append or a drop passes through the acknowledge
// state and waits for the output register; an upload start also moves each word into the
// packet store and emits each packet entry, and every move and emitted entry goes through a
// registered memory read.
// The word stores need no clearing after reset; only the state, pointers, counters and flags are reset.
// A stalled master side holds the sequencer wherever it has a result to deliver.
module two_priority_batch_uploader_core
    import tpbu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [EVENT_W-1:0]     s_axis_tdata,   // [31:0] event_word
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] kind, [2] high_priority
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] entry_word, [37:32] packet_size,
                                                   // [44:38] prio_waiting,
                                                   // [53:45] normal_waiting,
                                                   // [54] upload_busy, [55] zero
    output logic [KIND_W-1:0]      m_axis_tuser,   // [1:0] result_kind
    output logic                   m_axis_tlast    // last_in_packet
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_START   = 4'd1;
    localparam logic [3:0] S_SEND    = 4'd2;
    localparam logic [3:0] S_FILL    = 4'd3;
    localparam logic [3:0] S_FILL_P  = 4'd4;
    localparam logic [3:0] S_FILL_N  = 4'd5;
    localparam logic [3:0] S_ACK     = 4'd6;
    localparam logic [3:0] S_EMIT_RD = 4'd7;
    localparam logic [3:0] S_EMIT_LD = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [PRIO_AW-1:0] prio_head_reg, prio_head_next;
    logic [PRIO_CW-1:0] prio_cnt_reg, prio_cnt_next;
    logic [NORM_AW-1:0] norm_head_reg, norm_head_next;
    logic [NORM_CW-1:0] norm_cnt_reg, norm_cnt_next;
    logic [PKT_CW-1:0]  pkt_cnt_reg, pkt_cnt_next;
    logic [PKT_AW-1:0]  run_fill_reg, run_fill_next;
    logic               pending_reg, pending_next;
    logic               ack_reg, ack_next;
    kind_t              ack_kind_reg, ack_kind_next;
    logic               emit_reg, emit_next;
    logic [PKT_AW-1:0]  idx_reg, idx_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [EVENT_W-1:0]    out_word_reg, out_word_next;
    logic                  out_last_reg, out_last_next;
    logic [SIZE_W-1:0]     out_size_reg, out_size_next;
    logic [PRIO_OUT_W-1:0] out_prio_reg, out_prio_next;
    logic [NORM_OUT_W-1:0] out_norm_reg, out_norm_next;
    logic                  out_busy_reg, out_busy_next;

    logic               prio_we, norm_we, pkt_we;
    logic [STORE_W-1:0] prio_rdata, norm_rdata, pkt_rdata, pkt_wdata;
    logic [PRIO_AW-1:0] prio_tail;
    logic [NORM_AW-1:0] norm_tail;
    logic [PRIO_CW:0]   prio_sum;
    logic [NORM_CW:0]   norm_sum;
    logic [PKT_CW:0]    run_sum;
    logic               accept, out_free, prio_full, norm_full;
    logic               pkt_has_room, run_holds;
    kind_t              in_kind;
    logic               in_hp;

    assign in_kind = s_axis_tuser[KIND_W-1:0];
    assign in_hp   = s_axis_tuser[KIND_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Tail = (head + count) mod depth; the sum stays below twice the depth.
    assign prio_sum  = (PRIO_CW + 1)'(prio_head_reg) + (PRIO_CW + 1)'(prio_cnt_reg);
    assign prio_tail = (32'(prio_sum) >= 32'(PRIO_DEPTH))
                     ? PRIO_AW'(32'(prio_sum) - 32'(PRIO_DEPTH)) : PRIO_AW'(prio_sum);
    assign norm_sum  = (NORM_CW + 1)'(norm_head_reg) + (NORM_CW + 1)'(norm_cnt_reg);
    assign norm_tail = (32'(norm_sum) >= 32'(NORMAL_LIMIT))
                     ? NORM_AW'(32'(norm_sum) - 32'(NORMAL_LIMIT)) : NORM_AW'(norm_sum);
    assign run_sum   = (PKT_CW + 1)'(run_fill_reg) + (PKT_CW + 1)'(pkt_cnt_reg);

    assign prio_full    = (32'(prio_cnt_reg) >= 32'(PRIO_DEPTH));
    assign norm_full    = (32'(norm_cnt_reg) + 32'(pkt_cnt_reg) >= 32'(NORMAL_LIMIT));
    assign pkt_has_room = (32'(pkt_cnt_reg) < 32'(PACKET_MAX));
    // While the run fill is nonzero, normal words alone are sent only once enough wait to fill a packet.
    assign run_holds    = (run_fill_reg != '0) && (32'(norm_cnt_reg) < 32'(PACKET_MAX));

    assign pkt_wdata = (state_reg == S_FILL_P) ? prio_rdata : norm_rdata;

    tpbu_ram #(.WIDTH(STORE_W), .DEPTH(PRIO_DEPTH), .AW(PRIO_AW)) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (prio_tail),
        .wdata (s_axis_tdata[STORE_W-1:0]),
        .raddr (prio_head_reg),
        .rdata (prio_rdata)
    );

    tpbu_ram #(.WIDTH(STORE_W), .DEPTH(NORMAL_LIMIT), .AW(NORM_AW)) u_norm_ram (
        .clk   (clk),
        .we    (norm_we),
        .waddr (norm_tail),
        .wdata (s_axis_tdata[STORE_W-1:0]),
        .raddr (norm_head_reg),
        .rdata (norm_rdata)
    );

    tpbu_ram #(.WIDTH(STORE_W), .DEPTH(PACKET_MAX), .AW(PKT_AW)) u_pkt_ram (
        .clk   (clk),
        .we    (pkt_we),
        .waddr (pkt_cnt_reg[PKT_AW-1:0]),
        .wdata (pkt_wdata),
        .raddr (idx_reg),
        .rdata (pkt_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        prio_head_next = prio_head_reg;
        prio_cnt_next  = prio_cnt_reg;
        norm_head_next = norm_head_reg;
        norm_cnt_next  = norm_cnt_reg;
        pkt_cnt_next   = pkt_cnt_reg;
        run_fill_next  = run_fill_reg;
        pending_next   = pending_reg;
        ack_next       = ack_reg;
        ack_kind_next  = ack_kind_reg;
        emit_next      = emit_reg;
        idx_next       = idx_reg;
        prio_we        = 1'b0;
        norm_we        = 1'b0;
        pkt_we         = 1'b0;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        out_size_next  = out_size_reg;
        out_prio_next  = out_prio_reg;
        out_norm_next  = out_norm_reg;
        out_busy_next  = out_busy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ack_next  = 1'b0;
                    emit_next = 1'b0;
                    case (in_kind)
                        KIND_APPEND:
                        begin
                            ack_next   = 1'b1;
                            state_next = S_ACK;
                            if (in_hp)
                            begin
                                if (prio_full)
                                begin
                                    ack_kind_next = RK_DROP;
                                end
                                else
                                begin
                                    prio_we       = 1'b1;
                                    prio_cnt_next = prio_cnt_reg + 1'b1;
                                    ack_kind_next = RK_ACCEPT;
                                    state_next    = S_START;
                                end
                            end
                            else if (norm_full)
                            begin
                                ack_kind_next = RK_DROP;
                            end
                            else
                            begin
                                norm_we       = 1'b1;
                                norm_cnt_next = norm_cnt_reg + 1'b1;
                                ack_kind_next = RK_ACCEPT;
                            end
                        end
                        KIND_TICK:
                        begin
                            state_next = S_START;
                        end
                        KIND_DONE:
                        begin
                            if (pending_reg)
                            begin
                                run_fill_next = (32'(run_sum) >= 32'(PACKET_MAX))
                                              ? PKT_AW'(32'(run_sum) - 32'(PACKET_MAX))
                                              : PKT_AW'(run_sum);
                                pkt_cnt_next  = '0;
                                state_next    = S_SEND;
                            end
                        end
                        default:
                        begin
                            pending_next = 1'b0;
                        end
                    endcase
                end
            end
            S_START:
            begin
                if (pending_reg || (pkt_cnt_reg == '0 && prio_cnt_reg == '0
                                    && norm_cnt_reg == '0))
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    pending_next  = 1'b1;
                    run_fill_next = '0;
                    state_next    = S_SEND;
                end
            end
            S_SEND:
            begin
                if (prio_cnt_reg == '0
                    && ((norm_cnt_reg == '0 && pkt_cnt_reg == '0) || run_holds))
                begin
                    pending_next = 1'b0;
                    state_next   = S_ACK;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                // The queue memories read at their heads, so data is ready in the next state.
                if (prio_cnt_reg != '0 && pkt_has_room)
                begin
                    state_next = S_FILL_P;
                end
                else if (norm_cnt_reg != '0 && pkt_has_room)
                begin
                    state_next = S_FILL_N;
                end
                else
                begin
                    emit_next  = 1'b1;
                    state_next = S_ACK;
                end
            end
            S_FILL_P:
            begin
                pkt_we         = 1'b1;
                pkt_cnt_next   = pkt_cnt_reg + 1'b1;
                prio_cnt_next  = prio_cnt_reg - 1'b1;
                prio_head_next = (prio_head_reg == PRIO_AW'(PRIO_DEPTH - 1))
                               ? '0 : prio_head_reg + 1'b1;
                state_next     = S_FILL;
            end
            S_FILL_N:
            begin
                pkt_we         = 1'b1;
                pkt_cnt_next   = pkt_cnt_reg + 1'b1;
                norm_cnt_next  = norm_cnt_reg - 1'b1;
                norm_head_next = (norm_head_reg == NORM_AW'(NORMAL_LIMIT - 1))
                               ? '0 : norm_head_reg + 1'b1;
                state_next     = S_FILL;
            end
            S_ACK:
            begin
                if (!ack_reg || out_free)
                begin
                    if (ack_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = ack_kind_reg;
                        out_word_next  = '0;
                        out_last_next  = 1'b0;
                        out_size_next  = SIZE_W'(pkt_cnt_reg);
                        out_prio_next  = PRIO_OUT_W'(prio_cnt_reg);
                        out_norm_next  = NORM_OUT_W'(norm_cnt_reg);
                        out_busy_next  = pending_reg;
                    end
                    ack_next   = 1'b0;
                    idx_next   = '0;
                    state_next = (emit_reg && pkt_cnt_reg != '0) ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RK_ENTRY;
                    out_word_next  = EVENT_W'(pkt_rdata);
                    out_last_next  = (PKT_CW'(idx_reg) + 1'b1 == pkt_cnt_reg);
                    out_size_next  = SIZE_W'(pkt_cnt_reg);
                    out_prio_next  = PRIO_OUT_W'(prio_cnt_reg);
                    out_norm_next  = NORM_OUT_W'(norm_cnt_reg);
                    out_busy_next  = pending_reg;
                    if (PKT_CW'(idx_reg) + 1'b1 == pkt_cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prio_head_reg <= '0;
            prio_cnt_reg  <= '0;
            norm_head_reg <= '0;
            norm_cnt_reg  <= '0;
            pkt_cnt_reg   <= '0;
            run_fill_reg  <= '0;
            pending_reg   <= 1'b0;
            ack_reg       <= 1'b0;
            emit_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prio_head_reg <= prio_head_next;
            prio_cnt_reg  <= prio_cnt_next;
            norm_head_reg <= norm_head_next;
            norm_cnt_reg  <= norm_cnt_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            run_fill_reg  <= run_fill_next;
            pending_reg   <= pending_next;
            ack_reg       <= ack_next;
            emit_reg      <= emit_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_kind_reg <= ack_kind_next;
        out_kind_reg <= out_kind_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
        out_size_reg <= out_size_next;
        out_prio_reg <= out_prio_next;
        out_norm_reg <= out_norm_next;
        out_busy_reg <= out_busy_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_busy_reg, out_norm_reg, out_prio_reg,
                            out_size_reg, out_word_reg};

endmodule

// File: hw/rtl/tpbu_checker.sv
// Port-level checker for the batch uploader and its bind to the top level.
`include "two_priority_batch_uploader_core_macros.svh"

module tpbu_checker
    import tpbu_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]      m_axis_tuser,
    input logic                   m_axis_tlast
);

    logic                          stalled;
    logic                          ack_shown;
    logic                          known_kind;
    logic [OUT_TDATA_W+KIND_W:0]   out_bus;

    assign stalled    = m_axis_tvalid && !m_axis_tready;
    assign ack_shown  = m_axis_tvalid && (m_axis_tuser != RK_ENTRY);
    assign known_kind = (m_axis_tuser == RK_ACCEPT) || (m_axis_tuser == RK_DROP)
                        || (m_axis_tuser == RK_ENTRY);
    assign out_bus    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // Only packet entries may close a packet.
    `TPBU_ASSERT_NOW(a_last_on_entry, m_axis_tvalid && m_axis_tlast, m_axis_tuser == RK_ENTRY)

    // Append results carry no entry word.
    `TPBU_ASSERT_NOW(a_ack_word_zero, ack_shown, m_axis_tdata[EVENT_W-1:0] == '0)

    // No result of an unused kind is ever produced.
    `TPBU_ASSERT_NOW(a_kind_known, m_axis_tvalid, known_kind)

    // A stalled result keeps its contents.
    `TPBU_ASSERT_NEXT(a_stall_hold, stalled, m_axis_tvalid && $stable(out_bus))

endmodule

bind two_priority_batch_uploader_core tpbu_checker u_tpbu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/tb_two_priority_batch_uploader_core.sv
// Self-checking testbench of the two-priority batch uploader core.
module tb_two_priority_batch_uploader_core;
    import tpbu_pkg::*;

    localparam int SIZE_LSB    = EVENT_W;
    localparam int PRIO_LSB    = SIZE_LSB + SIZE_W;
    localparam int NORM_LSB    = PRIO_LSB + PRIO_OUT_W;
    localparam int BUSY_BIT    = NORM_LSB + NORM_OUT_W;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 400;
    localparam int RANDOM_REQS = 30;
    localparam logic [EVENT_W-1:0] WORD_MASK = {EVENT_W{1'b1}} >> (EVENT_W - STORE_W);

    typedef struct packed {
        kind_t                  rkind;
        logic [EVENT_W-1:0]     word;
        logic                   last;
        logic [SIZE_W-1:0]      size;
        logic [PRIO_OUT_W-1:0]  prio;
        logic [NORM_OUT_W-1:0]  norm;
        logic                   busy;
    } upload_result_t;

    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_THIRD, READY_RARE} ready_pattern_t;

    class upload_tracker;
        logic [EVENT_W-1:0] prio_q [PRIO_DEPTH];
        logic [EVENT_W-1:0] norm_q [NORMAL_LIMIT];
        logic [EVENT_W-1:0] packet [PACKET_MAX];
        int prio_head, prio_cnt, norm_head, norm_cnt, packet_cnt, run_fill;
        bit busy;
        upload_result_t step_results[$];
        upload_result_t awaited[$];
        int errors;

        function new();
            prio_head = 0; prio_cnt = 0;
            norm_head = 0; norm_cnt = 0;
            packet_cnt = 0; run_fill = 0;
            busy = 1'b0;
            errors = 0;
        endfunction

        function void add_result(kind_t k, logic [EVENT_W-1:0] w, logic l);
            upload_result_t r;
            r = '0;
            r.rkind = k;
            r.word = w;
            r.last = l;
            step_results.insert(step_results.size(), r);
        endfunction

        function void ship_packet(bit next);
            int i;
            if (next)
            begin
                run_fill = (run_fill + packet_cnt) % PACKET_MAX;
                packet_cnt = 0;
            end
            else
            begin
                run_fill = 0;
            end
            if (prio_cnt == 0)
            begin
                if (norm_cnt == 0 && packet_cnt == 0)
                begin
                    busy = 1'b0;
                    return;
                end
                // A short normal backlog waits for the next tick once a run has started.
                if (run_fill != 0 && norm_cnt < PACKET_MAX)
                begin
                    busy = 1'b0;
                    return;
                end
            end
            while (prio_cnt > 0 && packet_cnt < PACKET_MAX)
            begin
                packet[packet_cnt] = prio_q[prio_head];
                packet_cnt++;
                prio_head = (prio_head + 1) % PRIO_DEPTH;
                prio_cnt--;
            end
            while (norm_cnt > 0 && packet_cnt < PACKET_MAX)
            begin
                packet[packet_cnt] = norm_q[norm_head];
                packet_cnt++;
                norm_head = (norm_head + 1) % NORMAL_LIMIT;
                norm_cnt--;
            end
            for (i = 0; i < packet_cnt; i++)
                add_result(RK_ENTRY, packet[i], (i + 1 == packet_cnt));
        endfunction

        function void start_upload();
            if (busy)
                return;
            if (packet_cnt == 0 && prio_cnt == 0 && norm_cnt == 0)
                return;
            busy = 1'b1;
            ship_packet(1'b0);
        endfunction

        function void take_request(kind_t k, logic hp, logic [EVENT_W-1:0] w);
            upload_result_t r;
            step_results.delete();
            case (k)
                KIND_APPEND:
                    if (hp)
                    begin
                        if (prio_cnt >= PRIO_DEPTH)
                        begin
                            add_result(RK_DROP, '0, 1'b0);
                        end
                        else
                        begin
                            prio_q[(prio_head + prio_cnt) % PRIO_DEPTH] = w & WORD_MASK;
                            prio_cnt++;
                            add_result(RK_ACCEPT, '0, 1'b0);
                            start_upload();
                        end
                    end
                    else
                    begin
                        if (norm_cnt + packet_cnt >= NORMAL_LIMIT)
                        begin
                            add_result(RK_DROP, '0, 1'b0);
                        end
                        else
                        begin
                            norm_q[(norm_head + norm_cnt) % NORMAL_LIMIT] = w & WORD_MASK;
                            norm_cnt++;
                            add_result(RK_ACCEPT, '0, 1'b0);
                        end
                    end
                KIND_TICK:   start_upload();
                KIND_DONE:   if (busy) ship_packet(1'b1);
                KIND_FAILED: busy = 1'b0;
            endcase
            // Status fields reflect the state after the whole request.
            foreach (step_results[i])
            begin
                r = step_results[i];
                r.size = SIZE_W'(packet_cnt);
                r.prio = PRIO_OUT_W'(prio_cnt);
                r.norm = NORM_OUT_W'(norm_cnt);
                r.busy = busy;
                awaited.insert(awaited.size(), r);
            end
        endfunction

        function string describe(upload_result_t r);
            return $sformatf("kind=%0d word=%h last=%b size=%0d prio=%0d norm=%0d busy=%b",
                             r.rkind, r.word, r.last, r.size, r.prio, r.norm, r.busy);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d, kind_t u, logic l);
            upload_result_t got;
            upload_result_t want;
            got.rkind = u;
            got.word = d[EVENT_W-1:0];
            got.last = l;
            got.size = d[SIZE_LSB +: SIZE_W];
            got.prio = d[PRIO_LSB +: PRIO_OUT_W];
            got.norm = d[NORM_LSB +: NORM_OUT_W];
            got.busy = d[BUSY_BIT];
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = awaited.pop_front();
            if (got.rkind !== want.rkind || got.word !== want.word || got.last !== want.last ||
                got.size !== want.size || got.prio !== want.prio || got.norm !== want.norm ||
                got.busy !== want.busy)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %s, got %s", describe(want), describe(got));
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [EVENT_W-1:0]     s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    upload_tracker tracker = new();
    int  burst_left = 0;
    bit  hold_wanted = 1'b0;

    two_priority_batch_uploader_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [EVENT_W-1:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Offers one request, waits for it to be taken, then paces the sender in bursts.
    task automatic offer(input kind_t k, input logic hp, input logic [EVENT_W-1:0] w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= {hp, k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_request(k, hp, w);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 6))
                @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Sends completion reports until no upload is outstanding, with a retry now and then.
    task automatic drain_uploads();
        while (tracker.busy)
        begin
            if ($urandom_range(4) == 0)
            begin
                offer(KIND_FAILED, 1'($urandom_range(1)), pick_word());
                offer(KIND_TICK, 1'($urandom_range(1)), pick_word());
            end
            else
            begin
                offer(KIND_DONE, 1'($urandom_range(1)), pick_word());
            end
        end
    endtask

    initial
    begin
        int n;
        int r;
        kind_t k;
        logic hp;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle reports, retries and the run-fill hold-back.
        offer(KIND_TICK, 1'b0, '0);
        offer(KIND_DONE, 1'b1, '1);
        offer(KIND_FAILED, 1'b0, '0);
        offer(KIND_APPEND, 1'b0, '0);
        offer(KIND_APPEND, 1'b0, '1);
        offer(KIND_TICK, 1'b1, 32'h0000_0001);
        offer(KIND_APPEND, 1'b0, 32'hA5A5_A5A5);
        offer(KIND_APPEND, 1'b1, 32'h5A5A_5A5A);
        offer(KIND_FAILED, 1'b0, '0);
        offer(KIND_TICK, 1'b0, '0);
        offer(KIND_APPEND, 1'b0, 32'h8000_0001);
        offer(KIND_DONE, 1'b0, '0);
        offer(KIND_TICK, 1'b0, '0);
        offer(KIND_DONE, 1'b0, '0);
        offer(KIND_APPEND, 1'b1, '1);
        offer(KIND_FAILED, 1'b1, '0);
        offer(KIND_DONE, 1'b0, '0);
        offer(KIND_TICK, 1'b0, '0);
        offer(KIND_DONE, 1'b0, '0);

        // Fill both queues past their limits while one full packet is outstanding.
        repeat (40) offer(KIND_APPEND, 1'b0, pick_word());
        offer(KIND_TICK, 1'b0, pick_word());
        hold_wanted = 1'b1;
        repeat (PRIO_DEPTH + 2) offer(KIND_APPEND, 1'b1, pick_word());
        repeat (NORMAL_LIMIT - PACKET_MAX - 6) offer(KIND_APPEND, 1'b0, pick_word());
        drain_uploads();

        // Random traffic, with frequent completion reports while an upload is outstanding.
        n = 0;
        while (n < RANDOM_REQS)
        begin
            hp = 1'($urandom_range(1));
            if (tracker.busy && $urandom_range(99) < 55)
            begin
                k = ($urandom_range(99) < 80) ? KIND_DONE : KIND_FAILED;
                n++;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 45)
                begin
                    k = KIND_APPEND;
                    hp = 1'b0;
                end
                else if (r < 65)
                begin
                    k = KIND_APPEND;
                    hp = 1'b1;
                end
                else if (r < 90)
                begin
                    k = KIND_TICK;
                end
                else
                begin
                    k = (r < 95) ? KIND_DONE : KIND_FAILED;
                end
                if (k == KIND_APPEND || k == KIND_TICK || tracker.busy)
                    n++;
            end
            offer(k, hp, pick_word());
        end
        drain_uploads();
        s_axis_tvalid <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.awaited.size() != 0)
            $display("results never delivered: %0d", tracker.awaited.size());
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: its own ready pattern, plus one long hold-off to back up the input.
    initial
    begin
        int cyc;
        m_axis_tready = 1'b0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case (ready_pattern_t'((cyc / 150) % 4))
                    READY_ALWAYS: m_axis_tready <= 1'b1;
                    READY_MOSTLY: m_axis_tready <= ($urandom_range(9) < 7);
                    READY_THIRD:  m_axis_tready <= (cyc % 3 == 0);
                    READY_RARE:   m_axis_tready <= ($urandom_range(9) < 3);
                    default:      m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    initial
    begin
        #(12 * 1000000);
        $display("FAILURE");
        $finish;
    end

endmodule
